/* rtl/core/power_of_two_box_decimator_defines.svh */
// assertion macros shared by the decimator modules
`ifndef POWER_OF_TWO_BOX_DECIMATOR_DEFINES_SVH
`define POWER_OF_TWO_BOX_DECIMATOR_DEFINES_SVH

// check that is skipped while reset is high
`define P2BD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define P2BD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/p2bd_pkg.sv */
// shared types, constants and helper functions of the box decimator
package p2bd_pkg;

  localparam int MAX_SUM_SLOTS = 4096;
  localparam int SUM_WIDTH     = 56;
  localparam int SLOT_W        = $clog2(MAX_SUM_SLOTS);
  localparam int SLOT_CALC_W   = 15;
  localparam int SAMPLE_W      = 32;
  localparam int EXT_W         = SAMPLE_W + 1;
  localparam int COL_W         = 13;
  localparam int SUB_W         = 12;
  localparam int BAND_W        = 2;
  localparam int MAX_SHIFT     = 12;
  localparam int MAX_WIDTH     = 8192;
  localparam int MAX_BANDS     = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 14;

  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_32 = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_SHIFT,
    REG_Y_SHIFT,
    REG_LINE_WIDTH,
    REG_BAND_COUNT,
    REG_SIGNED,
    REG_IN_FMT,
    REG_OUT_FMT
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  x_shift;
    logic [3:0]  y_shift;
    logic [13:0] line_width;
    logic [2:0]  band_count;
    logic        signed_samples;
    logic [1:0]  input_format;
    logic [1:0]  output_format;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_shift:        4'd1,
    y_shift:        4'd1,
    line_width:     14'd640,
    band_count:     3'd1,
    signed_samples: 1'b0,
    input_format:   FMT_8,
    output_format:  FMT_8
  };

  // clamped settings as the datapath uses them
  typedef struct packed {
    logic [3:0]  xs;
    logic [3:0]  ys;
    logic [13:0] width;
    logic [2:0]  bands;
    logic        sgn;
    logic [1:0]  in_fmt;
    logic [1:0]  out_fmt;
    logic [5:0]  shift;
  } eff_t;

  // one accumulate job between front and back
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [EXT_W-1:0]  sample;
    logic              first;
    logic              last;
    logic              row_end;
  } op_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic [1:0] norm_fmt(logic [1:0] code);
    logic [1:0] r;
    case (code)
      FMT_8:   r = FMT_8;
      FMT_16:  r = FMT_16;
      default: r = FMT_32;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] fmt_bits(logic [1:0] code);
    logic [5:0] r;
    case (code)
      FMT_8:   r = 6'd8;
      FMT_16:  r = 6'd16;
      default: r = 6'd32;
    endcase
    return r;
  endfunction

  function automatic eff_t derive_eff(cfg_t c);
    eff_t       e;
    logic [6:0] need;
    logic [6:0] ob;
    e.xs = (c.x_shift > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : c.x_shift;
    e.ys = (c.y_shift > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : c.y_shift;
    if (c.line_width == '0) begin
      e.width = 14'd1;
    end else if (c.line_width > 14'(MAX_WIDTH)) begin
      e.width = 14'(MAX_WIDTH);
    end else begin
      e.width = c.line_width;
    end
    if (c.band_count == '0) begin
      e.bands = 3'd1;
    end else if (c.band_count > 3'(MAX_BANDS)) begin
      e.bands = 3'(MAX_BANDS);
    end else begin
      e.bands = c.band_count;
    end
    e.sgn     = c.signed_samples;
    e.in_fmt  = norm_fmt(c.input_format);
    e.out_fmt = norm_fmt(c.output_format);
    need = 7'(fmt_bits(e.in_fmt)) + 7'(e.xs) + 7'(e.ys);
    ob   = 7'(fmt_bits(e.out_fmt));
    e.shift = (need > ob) ? 6'(need - ob) : 6'd0;
    return e;
  endfunction

endpackage

/* rtl/core/p2bd_if.sv */
// valid/ready channels for input samples and reduced results
interface p2bd_pixel_if;
  import p2bd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                frame_start;
  modport source (output valid, sample, frame_start, input ready);
  modport sink (input valid, sample, frame_start, output ready);
endinterface

interface p2bd_result_if;
  import p2bd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] value;
  logic                row_end;
  modport source (output valid, value, row_end, input ready);
  modport sink (input valid, value, row_end, output ready);
endinterface

/* rtl/core/power_of_two_box_decimator.sv */
// top level of the power-of-two box decimator
// pixels carries raster-order samples (bands interleaved) with frame_start on
// the first sample of an image; results carries one reduced word per block
// and band, with row_end on the last word of an output row.
// each block of 2^x by 2^y pixels is summed per band in a column sum store of
// 4096 slots, one slot per block column and band; the sum is scaled down to
// the output format and given when the last sample of the block arrives.
// while results is ready, one word per clock is sustained in both directions and
// a word's slot goes through one read-modify-write per clock, with the previous
// sum forwarded; a result passes the job queue and the b1, b2 and output registers.
// a four-entry job queue separates the front counters from the store, so
// pixels stays ready while a result waits; when results stalls, the queue
// fills and then pixels drops ready.
// reset clears the counters, pipeline and queue and loads the default registers;
// the store is not cleared, each block starts by overwriting. the user must write
// registers through cfg_we, cfg_index and cfg_data only while idle, unchecked by the block.
module power_of_two_box_decimator (
  input  logic                                clk,
  input  logic                                rst,
  p2bd_pixel_if.sink                          pixels,
  p2bd_result_if.source                       results,
  input  logic                                cfg_we,
  input  logic [p2bd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [p2bd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import p2bd_pkg::*;

  cfg_t    cfg;
  eff_t    eff;
  logic    push, pop;
  op_t     push_op, head;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_X_SHIFT:    cfg.x_shift        <= cfg_data[3:0];
        REG_Y_SHIFT:    cfg.y_shift        <= cfg_data[3:0];
        REG_LINE_WIDTH: cfg.line_width     <= cfg_data[13:0];
        REG_BAND_COUNT: cfg.band_count     <= cfg_data[2:0];
        REG_SIGNED:     cfg.signed_samples <= cfg_data[0];
        REG_IN_FMT:     cfg.input_format   <= cfg_data[1:0];
        REG_OUT_FMT:    cfg.output_format  <= cfg_data[1:0];
        default:        cfg <= cfg;
      endcase
    end
  end

  assign eff = derive_eff(cfg);

  p2bd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .eff     (eff),
    .pixels  (pixels),
    .q_stat  (q_stat),
    .push    (push),
    .push_op (push_op)
  );

  p2bd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  p2bd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .eff     (eff),
    .q_stat  (q_stat),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

/* rtl/core/p2bd_front.sv */
// front end: raster counters, block classification and slot address
`include "power_of_two_box_decimator_defines.svh"
module p2bd_front (
  input  logic              clk,
  input  logic              rst,
  input  p2bd_pkg::eff_t    eff,
  p2bd_pixel_if.sink        pixels,
  input  p2bd_pkg::q_stat_t q_stat,
  output logic              push,
  output p2bd_pkg::op_t     push_op
);
  import p2bd_pkg::*;

  logic [COL_W-1:0]       in_column, in_column_next;
  logic [BAND_W-1:0]      band_index, band_index_next;
  logic [SUB_W-1:0]       sub_row, sub_row_next;

  logic                   accept;
  logic [COL_W-1:0]       col;
  logic [BAND_W-1:0]      band;
  logic [SUB_W-1:0]       sub;
  logic [COL_W-1:0]       blk;
  logic [13:0]            out_cols;
  logic [12:0]            xmask_full, ymask_full;
  logic [SUB_W-1:0]       xmask, ymask;
  logic [SUB_W-1:0]       col_low;
  logic [SLOT_CALC_W-1:0] slot_calc;
  logic                   in_range;
  logic [2:0]             band_inc;
  logic [13:0]            col_inc;

  assign pixels.ready = !q_stat.full;
  assign accept = pixels.valid && pixels.ready;

  // frame start clears the counters before the sample is placed
  assign col  = pixels.frame_start ? '0 : in_column;
  assign band = pixels.frame_start ? '0 : band_index;
  assign sub  = pixels.frame_start ? '0 : sub_row;

  assign blk        = col >> eff.xs;
  assign out_cols   = eff.width >> eff.xs;
  assign xmask_full = (13'd1 << eff.xs) - 13'd1;
  assign ymask_full = (13'd1 << eff.ys) - 13'd1;
  assign xmask      = xmask_full[SUB_W-1:0];
  assign ymask      = ymask_full[SUB_W-1:0];
  assign col_low    = col[SUB_W-1:0] & xmask;

  always_comb begin
    case (eff.bands)
      3'd1:    slot_calc = SLOT_CALC_W'(blk);
      3'd2:    slot_calc = SLOT_CALC_W'(blk) << 1;
      3'd3:    slot_calc = (SLOT_CALC_W'(blk) << 1) + SLOT_CALC_W'(blk);
      default: slot_calc = SLOT_CALC_W'(blk) << 2;
    endcase
    slot_calc = slot_calc + SLOT_CALC_W'(band);
  end

  assign in_range = ({1'b0, blk} < out_cols) && ({1'b0, band} < eff.bands) &&
                    (slot_calc < SLOT_CALC_W'(MAX_SUM_SLOTS));

  always_comb begin
    push_op.slot    = slot_calc[SLOT_W-1:0];
    push_op.first   = (sub == '0) && (col_low == '0);
    push_op.last    = (sub == ymask) && (col_low == xmask);
    push_op.row_end = ({1'b0, blk} == out_cols - 14'd1) &&
                      ({1'b0, band} == eff.bands - 3'd1);
    case (eff.in_fmt)
      FMT_8:   push_op.sample = {{(EXT_W-8){eff.sgn & pixels.sample[7]}},
                                 pixels.sample[7:0]};
      FMT_16:  push_op.sample = {{(EXT_W-16){eff.sgn & pixels.sample[15]}},
                                 pixels.sample[15:0]};
      default: push_op.sample = {eff.sgn & pixels.sample[SAMPLE_W-1], pixels.sample};
    endcase
  end

  assign push = accept && in_range;

  always_comb begin
    band_inc        = {1'b0, band} + 3'd1;
    col_inc         = {1'b0, col} + 14'd1;
    band_index_next = band_inc[BAND_W-1:0];
    in_column_next  = col;
    sub_row_next    = sub;
    if (band_inc >= eff.bands) begin
      band_index_next = '0;
      in_column_next  = col_inc[COL_W-1:0];
      if (col_inc >= eff.width) begin
        in_column_next = '0;
        sub_row_next   = (sub >= ymask) ? '0 : sub + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      band_index <= '0;
      sub_row    <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      band_index <= band_index_next;
      sub_row    <= sub_row_next;
    end
  end

  `P2BD_ASSERT(a_frame_restart, (accept && pixels.frame_start && eff.bands > 3'd1) |=> (band_index == 2'd1 && in_column == '0), "frame start did not restart the counters")
  `P2BD_ASSERT(a_no_push_when_full, push |-> !q_stat.full, "job pushed into a full queue")

endmodule

/* rtl/core/p2bd_queue.sv */
// small job queue between front end and accumulator
`include "power_of_two_box_decimator_defines.svh"
module p2bd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  p2bd_pkg::op_t     push_op,
  input  logic              pop,
  output p2bd_pkg::op_t     head,
  output p2bd_pkg::q_stat_t q_stat
);
  import p2bd_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign q_stat.full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.not_empty = (count != '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_stat.not_empty;
  assign head    = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `P2BD_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `P2BD_ASSERT(a_count_track, (do_push && !do_pop) |=> count == $past(count) + 1'b1, "queue count lost a word")

endmodule

/* rtl/core/p2bd_back.sv */
// back end: column sum store, read-modify-write with forwarding, scaling
`include "power_of_two_box_decimator_defines.svh"
module p2bd_back (
  input  logic              clk,
  input  logic              rst,
  input  p2bd_pkg::eff_t    eff,
  input  p2bd_pkg::q_stat_t q_stat,
  input  p2bd_pkg::op_t     head,
  output logic              pop,
  p2bd_result_if.source     results
);
  import p2bd_pkg::*;

  logic [SUM_WIDTH-1:0]        sums [MAX_SUM_SLOTS];

  logic                        advance;
  logic                        b1_valid, b2_valid, out_valid;
  op_t                         b1;
  logic [SUM_WIDTH-1:0]        rdata;
  logic                        fwd_hit;
  logic [SUM_WIDTH-1:0]        fwd_data;
  logic [SUM_WIDTH-1:0]        b1_base, b1_ext, b1_acc;
  logic [SUM_WIDTH-1:0]        b2_acc;
  logic                        b2_row_end;
  logic signed [SUM_WIDTH-1:0] b2_acc_s;
  logic [SUM_WIDTH-1:0]        sh_arith, sh_logic, shifted;
  logic [SAMPLE_W-1:0]         shaped;
  logic [SAMPLE_W-1:0]         out_value;
  logic                        out_row_end;

  assign advance = !out_valid || results.ready;
  assign pop     = advance && q_stat.not_empty;

  // store reads old data when the same slot is written on that edge
  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= sums[head.slot];
    end
    if (advance && b1_valid) begin
      sums[b1.slot] <= b1_acc;
    end
  end

  assign b1_base = fwd_hit ? fwd_data : rdata;
  assign b1_ext  = {{(SUM_WIDTH-EXT_W){b1.sample[EXT_W-1]}}, b1.sample};
  assign b1_acc  = b1.first ? b1_ext : b1_base + b1_ext;

  assign b2_acc_s = b2_acc;
  assign sh_arith = b2_acc_s >>> eff.shift;
  assign sh_logic = b2_acc >> eff.shift;
  assign shifted  = eff.sgn ? sh_arith : sh_logic;

  always_comb begin
    case (eff.out_fmt)
      FMT_8:   shaped = {{(SAMPLE_W-8){1'b0}}, shifted[7:0]};
      FMT_16:  shaped = {{(SAMPLE_W-16){1'b0}}, shifted[15:0]};
      default: shaped = shifted[SAMPLE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b1_valid  <= q_stat.not_empty;
      b2_valid  <= b1_valid && b1.last;
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1          <= head;
      fwd_hit     <= b1_valid && (b1.slot == head.slot);
      fwd_data    <= b1_acc;
      b2_acc      <= b1_acc;
      b2_row_end  <= b1.row_end;
      out_value   <= shaped;
      out_row_end <= b2_row_end;
    end
  end

  assign results.valid   = out_valid;
  assign results.value   = out_value;
  assign results.row_end = out_row_end;

  `P2BD_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result offered right after reset")
  `P2BD_ASSERT(a_stall_holds_queue, (out_valid && !results.ready) |-> !pop, "queue popped while output stalled")
  `P2BD_ASSERT(a_fwd_needs_prior, (b1_valid && fwd_hit) |-> $past(b1_valid), "forwarded sum without a prior job")

endmodule

/* tb/power_of_two_box_decimator_tb.sv */
// self-checking testbench for the power-of-two box decimator
module power_of_two_box_decimator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import p2bd_pkg::*;

  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_WORDS = 450;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_start;
  } raster_word_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic                row_end;
  } block_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  p2bd_pixel_if pixels();
  p2bd_result_if results();

  power_of_two_box_decimator dut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  raster_word_t sample_feed[$];
  block_word_t block_words_due[$];

  // mirror of the block's registers and counters
  cfg_t shadow;
  logic [SUM_WIDTH-1:0] col_sum [MAX_SUM_SLOTS];
  int unsigned pos_col, pos_band, pos_row;

  int unsigned failures;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned settings_used;
  int unsigned random_words;
  bit steady_phase;

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  // block sum update for one accepted word, queues the reduced word when a block closes
  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] raw, input logic opens);
    int unsigned xs, ys, width, bands, ib, ob, xmask, ymask, out_cols, blk, slot, sh;
    logic [63:0] wide, imask;
    logic [SUM_WIDTH-1:0] acc;
    logic sgn;
    block_word_t word;
    xs = (shadow.x_shift > MAX_SHIFT) ? MAX_SHIFT : shadow.x_shift;
    ys = (shadow.y_shift > MAX_SHIFT) ? MAX_SHIFT : shadow.y_shift;
    if (shadow.line_width == 0) begin
      width = 1;
    end else if (shadow.line_width > MAX_WIDTH) begin
      width = MAX_WIDTH;
    end else begin
      width = shadow.line_width;
    end
    if (shadow.band_count == 0) begin
      bands = 1;
    end else if (shadow.band_count > MAX_BANDS) begin
      bands = MAX_BANDS;
    end else begin
      bands = shadow.band_count;
    end
    ib = (shadow.input_format == FMT_8) ? 8 : (shadow.input_format == FMT_16) ? 16 : 32;
    ob = (shadow.output_format == FMT_8) ? 8 : (shadow.output_format == FMT_16) ? 16 : 32;
    sgn = shadow.signed_samples;
    xmask = (1 << xs) - 1;
    ymask = (1 << ys) - 1;
    out_cols = width >> xs;

    if (opens) begin
      pos_col = 0;
      pos_band = 0;
      pos_row = 0;
    end

    blk = pos_col >> xs;
    if (blk < out_cols && pos_band < bands) begin
      slot = blk * bands + pos_band;
      if (slot < MAX_SUM_SLOTS) begin
        imask = (64'd1 << ib) - 64'd1;
        wide = 64'(raw) & imask;
        if (sgn && wide[ib-1]) wide = wide | ~imask;
        if (pos_row == 0 && (pos_col & xmask) == 0) begin
          acc = wide[SUM_WIDTH-1:0];
        end else begin
          acc = col_sum[slot] + wide[SUM_WIDTH-1:0];
        end
        col_sum[slot] = acc;
        if (pos_row == ymask && (pos_col & xmask) == xmask) begin
          sh = (ib + xs + ys > ob) ? ib + xs + ys - ob : 0;
          wide = {{(64-SUM_WIDTH){sgn & acc[SUM_WIDTH-1]}}, acc};
          if (sgn) begin
            wide = $signed(wide) >>> sh;
          end else begin
            wide = wide >> sh;
          end
          word.value = 32'(wide & ((64'd1 << ob) - 64'd1));
          word.row_end = (blk == out_cols - 1) && (pos_band == bands - 1);
          block_words_due.push_back(word);
        end
      end
    end

    pos_band++;
    if (pos_band >= bands) begin
      pos_band = 0;
      pos_col++;
      if (pos_col >= width) begin
        pos_col = 0;
        if (pos_row >= ymask) pos_row = 0;
        else pos_row++;
      end
    end
    pos_col &= 32'h1FFF;
    pos_band &= 32'h3;
    pos_row &= 32'hFFF;
  endtask

  // input side: word source fed from sample_feed
  raster_word_t next_word;
  int unsigned feed_gap;
  always @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
      feed_gap <= 0;
    end else if (!pixels.valid || pixels.ready) begin
      if (feed_gap != 0) begin
        pixels.valid <= 1'b0;
        feed_gap <= feed_gap - 1;
      end else if (sample_feed.size() != 0) begin
        next_word = sample_feed.pop_front();
        pixels.valid <= 1'b1;
        pixels.sample <= next_word.sample;
        pixels.frame_start <= next_word.frame_start;
        feed_gap <= pick_idle();
      end else begin
        pixels.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pixels.valid && pixels.ready) begin
      accumulate_sample(pixels.sample, pixels.frame_start);
    end
  end

  // output side: random back-pressure
  int unsigned hold_ready;
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      hold_ready <= 0;
    end else if (hold_ready != 0) begin
      results.ready <= 1'b0;
      hold_ready <= hold_ready - 1;
    end else begin
      results.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold_ready <= pick_idle();
    end
  end

  block_word_t due;
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (block_words_due.size() == 0) begin
        note_failure($sformatf("unexpected word: value %h row_end %0b",
                               results.value, results.row_end));
      end else begin
        due = block_words_due.pop_front();
        if (results.value !== due.value || results.row_end !== due.row_end) begin
          note_failure($sformatf(
            "word %0d mismatch: expected value %h row_end %0b, got value %h row_end %0b",
            words_checked, due.value, due.row_end, results.value, results.row_end));
        end
      end
      words_checked++;
    end
  end

  int unsigned quiet;
  always @(posedge clk) begin
    if (rst || (pixels.valid && pixels.ready) || (results.valid && results.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d words still due", quiet,
                 block_words_due.size());
        $display("power_of_two_box_decimator verification failed");
        $finish;
      end
    end
  end

  // wait until every queued word is taken and every due word has come out
  task automatic settle();
    do @(negedge clk);
    while (sample_feed.size() != 0 || pixels.valid || block_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_X_SHIFT:    shadow.x_shift = val[3:0];
      REG_Y_SHIFT:    shadow.y_shift = val[3:0];
      REG_LINE_WIDTH: shadow.line_width = val[13:0];
      REG_BAND_COUNT: shadow.band_count = val[2:0];
      REG_SIGNED:     shadow.signed_samples = val[0];
      REG_IN_FMT:     shadow.input_format = val[1:0];
      REG_OUT_FMT:    shadow.output_format = val[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] xs, input logic [3:0] ys,
                           input logic [13:0] width, input logic [2:0] bands,
                           input logic sgn, input logic [1:0] in_fmt,
                           input logic [1:0] out_fmt);
    settle();
    write_reg(REG_X_SHIFT, 14'(xs));
    write_reg(REG_Y_SHIFT, 14'(ys));
    write_reg(REG_LINE_WIDTH, width);
    write_reg(REG_BAND_COUNT, 14'(bands));
    write_reg(REG_SIGNED, 14'(sgn));
    write_reg(REG_IN_FMT, 14'(in_fmt));
    write_reg(REG_OUT_FMT, 14'(out_fmt));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic push_word(input logic [SAMPLE_W-1:0] sample, input logic fs);
    raster_word_t w;
    w.sample = sample;
    w.frame_start = fs;
    sample_feed.push_back(w);
    words_sent++;
  endtask

  // extremes of the current input width, with junk in the unused upper bits, or a fully random word
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned ib;
    logic [SAMPLE_W-1:0] m, junk;
    ib = (shadow.input_format == FMT_8) ? 8 : (shadow.input_format == FMT_16) ? 16 : 32;
    m = (32'd1 << ib) - 32'd1;
    junk = $urandom() & ~m;
    case ($urandom_range(0, 7))
      0: return junk;
      1: return junk | m;
      2: return junk | (32'd1 << (ib - 1));
      3: return junk | (m >> 1);
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_rows(input int unsigned rows, input int unsigned row_len,
                            input bit opens, input bit noisy);
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < row_len; i++) begin
        push_word(pick_sample(),
                  (opens && r == 0 && i == 0) || (noisy && $urandom_range(0, 199) == 0));
      end
    end
  endtask

  task automatic random_phase();
    logic [3:0] xs, ys;
    logic [13:0] width;
    logic [2:0] bands;
    int unsigned we, be, row_len, span, blocks, rows;
    xs = 4'($urandom_range(0, 3));
    ys = 4'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: width = 14'd0;
      1: width = 14'($urandom_range(21, 40));
      default: width = 14'($urandom_range(1, 20));
    endcase
    bands = 3'($urandom_range(0, 7));
    configure(xs, ys, width, bands, 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    we = (width == 0) ? 1 : width;
    be = (bands == 0) ? 1 : (bands > MAX_BANDS ? MAX_BANDS : bands);
    row_len = we * be;
    span = row_len << ys;
    blocks = (span >= 160) ? 1 : 160 / span;
    // whole block rows plus a trailing partial one of random height, possibly empty
    rows = (blocks << ys) + $urandom_range(0, (1 << ys) - 1);
    steady_phase = ($urandom_range(0, 4) == 0);
    queue_rows(rows, row_len, 1'b1, $urandom_range(0, 2) == 0);
    if ((we >> xs) != 0) random_words += rows * row_len;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixels.valid = 1'b0;
    pixels.sample = '0;
    pixels.frame_start = 1'b0;
    results.ready = 1'b0;
    shadow = CFG_RESET;
    pos_col = 0;
    pos_band = 0;
    pos_row = 0;
    steady_phase = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single-pixel blocks, 32-bit in, 8-bit out
    configure(4'd0, 4'd0, 14'd4, 3'd1, 1'b0, FMT_32, FMT_8);
    push_word(32'h0000_0000, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h7FFF_FFFF, 1'b0);

    // signed 8-bit, two bands, sum left unshifted into 32 bits
    configure(4'd1, 4'd1, 14'd2, 3'd2, 1'b1, FMT_8, FMT_32);
    push_word(32'h0000_0080, 1'b1);
    push_word(32'hABCD_EF7F, 1'b0);
    push_word(32'h1234_5680, 1'b0);
    push_word(32'hFFFF_FF80, 1'b0);
    push_word(32'h0000_0080, 1'b0);
    push_word(32'h0000_007F, 1'b0);
    push_word(32'h0000_0080, 1'b0);
    push_word(32'h0000_0080, 1'b0);

    // format code three on both sides, trailing partial column dropped
    configure(4'd1, 4'd0, 14'd3, 3'd1, 1'b1, FMT_SPARE, FMT_SPARE);
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h7FFF_FFFF, 1'b0);
    push_word(32'h0000_0005, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);

    // zero width and too many bands, frame restarted mid row
    configure(4'd0, 4'd0, 14'd0, 3'd7, 1'b0, FMT_16, FMT_8);
    push_word(32'h0000_FFFF, 1'b1);
    push_word(32'h1234_8000, 1'b0);
    push_word(32'hFFFF_0001, 1'b1);
    push_word(32'h0000_7FFF, 1'b0);
    push_word(32'h0000_0100, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);

    // settings shrunk inside an image: column and row counters past their new limits
    configure(4'd1, 4'd2, 14'd16, 3'd1, 1'b0, FMT_8, FMT_16);
    queue_rows(3, 16, 1'b1, 1'b0);
    queue_rows(1, 6, 1'b0, 1'b0);
    configure(4'd1, 4'd1, 14'd4, 3'd1, 1'b0, FMT_8, FMT_16);
    queue_rows(1, 1, 1'b0, 1'b0);
    queue_rows(2, 4, 1'b0, 1'b0);

    while (random_words < RANDOM_WORDS) random_phase();

    // over-range shift and width: the wide block never closes within the row
    steady_phase = 1'b0;
    configure(4'd15, 4'd0, 14'd16383, 3'd1, 1'b1, FMT_32, FMT_8);
    queue_rows(1, 64, 1'b1, 1'b0);
    // over-range vertical shift, one column: the tall block never closes
    configure(4'd0, 4'd13, 14'd1, 3'd1, 1'b0, FMT_8, FMT_32);
    queue_rows(64, 1, 1'b1, 1'b0);

    settle();
    $display("%0d pixel words over %0d register settings, %0d block words checked",
             words_sent, settings_used, words_checked);
    if (failures == 0) begin
      $display("power_of_two_box_decimator verification clean");
    end else begin
      $display("%0d failures", failures);
      $display("power_of_two_box_decimator verification failed");
    end
    $finish;
  end

endmodule
